// ===== rtl/annulus_radial_penalty_sum_macros.svh =====
// Assertion macros for the annulus radial penalty sum block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef ANNULUS_RADIAL_PENALTY_SUM_MACROS_SVH
`define ANNULUS_RADIAL_PENALTY_SUM_MACROS_SVH

// Checked only while out of reset.
`define ARPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define ARPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/arps_pkg.sv =====
// Package for the annulus radial penalty sum block: widths, register
// indexes and the control types of the shared iterative unit. No dependencies.
`default_nettype none

package arps_pkg;

  localparam int CoordW   = 24;
  localparam int RadW     = 24;
  localparam int SqW      = 2 * RadW;
  localparam int AccW     = 64;
  localparam int ScaleW   = 8;
  localparam int DvdW     = AccW + ScaleW;
  localparam int RemW     = RadW + 2;
  localparam int CntW     = 7;
  localparam int CfgIdxW  = 2;

  localparam int SqrtSteps = RadW;
  localparam int DivSteps  = DvdW;

  localparam logic [CfgIdxW-1:0] CFG_INNER = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OUTER = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIGMA = 2'd2;

  localparam logic [RadW-1:0] INNER_RST = '0;
  localparam logic [RadW-1:0] OUTER_RST = '1;
  localparam logic [RadW-1:0] SIGMA_RST = RadW'(256);

  localparam logic [AccW-1:0] ACC_SAT = '1;

  typedef enum logic {
    ITER_SQRT,
    ITER_DIV
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_sts_t;

endpackage

`default_nettype wire

// ===== rtl/arps_if.sv =====
// Valid/ready channel interfaces for the particle words and the score words.
// Depends on arps_pkg for the field widths.
`default_nettype none

interface arps_in_if;
  import arps_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [CoordW-1:0] x_coord;
  logic signed [CoordW-1:0] y_coord;
  logic                     last_particle;

  modport source (output valid, x_coord, y_coord, last_particle, input ready);
  modport sink   (input valid, x_coord, y_coord, last_particle, output ready);
endinterface

interface arps_out_if;
  import arps_pkg::*;

  logic            valid;
  logic            ready;
  logic [AccW-1:0] score;
  logic            saturated;

  modport source (output valid, score, saturated, input ready);
  modport sink   (input valid, score, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/arps_sq.sv =====
// Registered 24-bit squarer shared by the coordinate and penalty squares.
// Depends on arps_pkg.
`default_nettype none

module arps_sq (
  input  wire logic                     clk,
  input  wire logic [arps_pkg::RadW-1:0] op,
  output logic      [arps_pkg::SqW-1:0]  sq
);
  import arps_pkg::*;

  logic [SqW-1:0] sq_r;

  always_ff @(posedge clk) begin
    sq_r <= SqW'(op) * SqW'(op);
  end

  assign sq = sq_r;

endmodule

`default_nettype wire

// ===== rtl/arps_iter.sv =====
// Shared compare-subtract unit run as a restoring square root (one root bit
// per cycle) or a restoring divide (one quotient bit per cycle). Uses arps_pkg.
`default_nettype none

module arps_iter (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire arps_pkg::iter_ctl_t        ctl,
  input  wire logic [arps_pkg::DvdW-1:0]  opnd,
  input  wire logic [arps_pkg::RadW-1:0]  divisor,
  output arps_pkg::iter_sts_t             sts,
  output logic      [arps_pkg::DvdW-1:0]  quot,
  output logic      [arps_pkg::RadW-1:0]  root
);
  import arps_pkg::*;

  logic             busy_r;
  logic             done_r;
  iter_mode_t       mode_r;
  logic [CntW-1:0]  cnt_r;
  logic [DvdW-1:0]  sh_r;
  logic [RemW-1:0]  rem_r;
  logic [RadW-1:0]  root_r;
  logic [RadW-1:0]  dvs_r;

  logic [RemW-1:0]  cand;
  logic [RemW-1:0]  trial;
  logic [RemW-1:0]  diff;
  logic             borrow;
  logic             ge;
  logic [RemW-1:0]  rem_nxt;

  always_comb begin
    if (mode_r == ITER_SQRT) begin
      cand  = {rem_r[RemW-3:0], sh_r[DvdW-1 -: 2]};
      trial = {root_r, 2'b01};
    end else begin
      cand  = {rem_r[RemW-2:0], sh_r[DvdW-1]};
      trial = {2'b00, dvs_r};
    end
    {borrow, diff} = {1'b0, cand} - {1'b0, trial};
    ge      = !borrow;
    rem_nxt = ge ? diff : cand;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      mode_r <= ITER_SQRT;
      cnt_r  <= '0;
    end else begin
      if (ctl.start) begin
        busy_r <= 1'b1;
        done_r <= 1'b0;
        mode_r <= ctl.mode;
        cnt_r  <= (ctl.mode == ITER_SQRT) ? CntW'(SqrtSteps - 1) : CntW'(DivSteps - 1);
      end else if (busy_r) begin
        cnt_r  <= cnt_r - 1'b1;
        done_r <= (cnt_r == '0);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end
      end else begin
        done_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      sh_r   <= opnd;
      rem_r  <= '0;
      root_r <= '0;
      dvs_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      if (mode_r == ITER_SQRT) begin
        sh_r   <= {sh_r[DvdW-3:0], 2'b00};
        root_r <= {root_r[RadW-2:0], ge};
      end else begin
        sh_r <= {sh_r[DvdW-2:0], ge};
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot     = sh_r;
  assign root     = root_r;

endmodule

`default_nettype wire

// ===== rtl/annulus_radial_penalty_sum.sv =====
// Channel    Dir  Fields                               Handshake
// in_ch      in   x_coord, y_coord, last_particle      valid/ready
// out_ch     out  score, saturated                     valid/ready
// cfg_*      in   cfg_idx, cfg_wdata                   cfg_we, no wait
//
// Particle words are accepted only in the idle state; the 24-step square root on
// the shared compare-subtract unit takes most of the time from one acceptance to the next.
// A last word also waits for the 72-step divide and the score hand-off.
// Reset is synchronous and active low; there is no clearing pass.
// A pending score word does not block new particles, only the next score.
`default_nettype none

`include "annulus_radial_penalty_sum_macros.svh"

module annulus_radial_penalty_sum (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  arps_in_if.sink                            in_ch,
  arps_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [arps_pkg::CfgIdxW-1:0]  cfg_idx,
  input  wire logic [arps_pkg::RadW-1:0]     cfg_wdata
);
  import arps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_RSTART,
    ST_ROOT,
    ST_PEN,
    ST_SQD,
    ST_ACC,
    ST_DSTART,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t           state_r;
  logic [RadW-1:0]  inner_r;
  logic [RadW-1:0]  outer_r;
  logic [RadW-1:0]  sigma_r;
  logic [RadW-1:0]  ax_r;
  logic [RadW-1:0]  ay_r;
  logic             last_r;
  logic [SqW-1:0]   sq_r;
  logic [RadW-1:0]  diff_r;
  logic [AccW-1:0]  acc_r;
  logic             ovf_r;
  logic             out_vld_r;
  logic [AccW-1:0]  score_r;
  logic             sat_r;

  logic [RadW-1:0]  sq_op;
  logic [SqW-1:0]   sq_out;
  iter_ctl_t        ictl;
  iter_sts_t        ists;
  logic [DvdW-1:0]  iopnd;
  logic [RadW-1:0]  divisor;
  logic [DvdW-1:0]  quot;
  logic [RadW-1:0]  root;
  logic [AccW:0]    acc_sum;
  logic             q_big;
  logic             fin_go;
  logic [RadW-1:0]  pen_diff;

  always_comb begin
    unique case (state_r)
      ST_SQX:  sq_op = ax_r;
      ST_SQY:  sq_op = ay_r;
      default: sq_op = diff_r;
    endcase
  end

  arps_sq u_sq (
    .clk (clk),
    .op  (sq_op),
    .sq  (sq_out)
  );

  assign divisor    = (sigma_r == '0) ? RadW'(1) : sigma_r;
  assign ictl.start = (state_r == ST_RSTART) || (state_r == ST_DSTART);
  assign ictl.mode  = (state_r == ST_DSTART) ? ITER_DIV : ITER_SQRT;
  assign iopnd      = (state_r == ST_DSTART) ? {acc_r, ScaleW'(0)}
                                             : {sq_r + sq_out, RadW'(0)};

  arps_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ictl),
    .opnd    (iopnd),
    .divisor (divisor),
    .sts     (ists),
    .quot    (quot),
    .root    (root)
  );

  always_comb begin
    priority if (root < inner_r) begin
      pen_diff = inner_r - root;
    end else if (root > outer_r) begin
      pen_diff = root - outer_r;
    end else begin
      pen_diff = '0;
    end
  end

  assign acc_sum = {1'b0, acc_r} + {{(AccW + 1 - SqW){1'b0}}, sq_out};
  assign q_big   = |quot[DvdW-1:AccW];
  assign fin_go  = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      inner_r   <= INNER_RST;
      outer_r   <= OUTER_RST;
      sigma_r   <= SIGMA_RST;
      acc_r     <= '0;
      ovf_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_INNER: inner_r <= cfg_wdata;
          CFG_OUTER: outer_r <= cfg_wdata;
          CFG_SIGMA: sigma_r <= cfg_wdata;
          default:   ;
        endcase
      end

      if (out_vld_r && out_ch.ready && !fin_go) begin
        out_vld_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            ax_r    <= in_ch.x_coord[CoordW-1] ? RadW'(-in_ch.x_coord) : RadW'(in_ch.x_coord);
            ay_r    <= in_ch.y_coord[CoordW-1] ? RadW'(-in_ch.y_coord) : RadW'(in_ch.y_coord);
            last_r  <= in_ch.last_particle;
            state_r <= ST_SQX;
          end
        end
        ST_SQX:    state_r <= ST_SQY;
        ST_SQY: begin
          sq_r    <= sq_out;
          state_r <= ST_RSTART;
        end
        ST_RSTART: state_r <= ST_ROOT;
        ST_ROOT: begin
          if (ists.done) begin
            state_r <= ST_PEN;
          end
        end
        ST_PEN: begin
          diff_r  <= pen_diff;
          state_r <= ST_SQD;
        end
        ST_SQD:    state_r <= ST_ACC;
        ST_ACC: begin
          if (acc_sum[AccW]) begin
            acc_r <= ACC_SAT;
            ovf_r <= 1'b1;
          end else begin
            acc_r <= acc_sum[AccW-1:0];
          end
          state_r <= last_r ? ST_DSTART : ST_IDLE;
        end
        ST_DSTART: state_r <= ST_DIV;
        ST_DIV: begin
          if (ists.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_go) begin
            score_r   <= q_big ? ACC_SAT : quot[AccW-1:0];
            sat_r     <= ovf_r || q_big;
            out_vld_r <= 1'b1;
            acc_r     <= '0;
            ovf_r     <= 1'b0;
            state_r   <= ST_IDLE;
          end
        end
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_vld_r;
  assign out_ch.score     = score_r;
  assign out_ch.saturated = sat_r;

  `ARPS_ASSERT(a_iter_owned, ists.busy |-> (state_r == ST_ROOT || state_r == ST_DIV), "iterative unit busy outside a wait state")
  `ARPS_ASSERT(a_ovf_pins_sum, ovf_r |-> (acc_r == ACC_SAT), "overflow flag set but sum not pinned")
  `ARPS_ASSERT(a_fin_clears, fin_go |=> (out_vld_r && acc_r == '0 && !ovf_r), "score hand-off did not clear the sum")
  `ARPS_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!out_vld_r && state_r == ST_IDLE), "reset left the block busy")

endmodule

`default_nettype wire

// ===== tb/annulus_radial_penalty_sum_tb.sv =====
// Self-checking testbench for annulus_radial_penalty_sum: a directed table, then random
// particle sets under several radius, sigma and idling settings, checked against a predictor.
// Depends on arps_pkg, the arps_in_if/arps_out_if channel interfaces and the block's RTL.
module annulus_radial_penalty_sum_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import arps_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 128;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PHASES = 8;
  localparam int WORDS_PER_PHASE = 110;
  localparam int OVERFLOW_SET = 260;
  localparam logic signed [CoordW-1:0] COORD_MIN = {1'b1, {(CoordW-1){1'b0}}};
  localparam logic signed [CoordW-1:0] COORD_MAX = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [RadW-1:0] RAD_MAX = '1;

  typedef enum logic {
    ROW_WORD,
    ROW_REG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                kind;
    logic [CfgIdxW-1:0]       idx;
    logic [RadW-1:0]          val;
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic                     last;
    logic [15:0]              reps;
    logic                     typed;
    logic [AccW-1:0]          score;
    logic                     saturated;
  } stim_row_t;

  typedef struct packed {
    logic [AccW-1:0] score;
    logic            saturated;
  } score_word_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [RadW-1:0]    cfg_wdata;

  arps_in_if  in_ch();
  arps_out_if out_ch();

  annulus_radial_penalty_sum u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  logic [RadW-1:0] band_inner;
  logic [RadW-1:0] band_outer;
  logic [RadW-1:0] band_sigma;
  logic [AccW-1:0] penalty_total;
  logic            total_clipped;

  score_word_t expected_scores[$];
  stim_row_t   directed_rows[$];
  int          errors;
  int          cycles;
  int          src_idle_pct;
  int          sink_stall_pct;
  bit          streaming;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [RadW-1:0] radial_distance(logic signed [CoordW-1:0] x,
                                                      logic signed [CoordW-1:0] y);
    logic [CoordW-1:0] ax;
    logic [CoordW-1:0] ay;
    logic [63:0]       power;
    logic [RadW-1:0]   root;
    logic [RadW-1:0]   trial;
    int                b;
    ax = x[CoordW-1] ? ~x + 1'b1 : x;
    ay = y[CoordW-1] ? ~y + 1'b1 : y;
    power = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay);
    root = '0;
    for (b = RadW - 1; b >= 0; b--) begin
      trial = root | (RadW'(1) << b);
      if (64'(trial) * 64'(trial) <= power) root = trial;
    end
    return root;
  endfunction

  function automatic logic [AccW-1:0] band_penalty(logic [RadW-1:0] d);
    logic [RadW-1:0] gap;
    if (d < band_inner) gap = band_inner - d;
    else if (d > band_outer) gap = d - band_outer;
    else gap = '0;
    return AccW'(gap) * AccW'(gap);
  endfunction

  // Adds one particle's penalty; on the last word of a set, yields the score word.
  function automatic bit absorb_word(logic signed [CoordW-1:0] x, logic signed [CoordW-1:0] y,
                                     logic last, output score_word_t w);
    logic [AccW:0]          grown;
    logic [AccW+ScaleW-1:0] quotient;
    logic [RadW-1:0]        divisor;
    w = '0;
    grown = {1'b0, penalty_total} + band_penalty(radial_distance(x, y));
    if (grown[AccW]) begin
      penalty_total = ACC_SAT;
      total_clipped = 1'b1;
    end else begin
      penalty_total = grown[AccW-1:0];
    end
    if (!last) return 1'b0;
    divisor = (band_sigma == '0) ? RadW'(1) : band_sigma;
    quotient = {penalty_total, {ScaleW{1'b0}}} / divisor;
    if (quotient > ACC_SAT) begin
      w.score = ACC_SAT;
      w.saturated = 1'b1;
    end else begin
      w.score = quotient[AccW-1:0];
      w.saturated = total_clipped;
    end
    penalty_total = '0;
    total_clipped = 1'b0;
    return 1'b1;
  endfunction

  function automatic stim_row_t word_row(logic signed [CoordW-1:0] x,
                                         logic signed [CoordW-1:0] y, logic last,
                                         int reps = 1, bit typed = 0,
                                         logic [AccW-1:0] score = '0, logic sat = 1'b0);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WORD;
    r.x = x;
    r.y = y;
    r.last = last;
    r.reps = 16'(reps);
    r.typed = typed;
    r.score = score;
    r.saturated = sat;
    return r;
  endfunction

  function automatic stim_row_t reg_row(logic [CfgIdxW-1:0] idx, logic [RadW-1:0] val);
    stim_row_t r;
    r = '0;
    r.kind = ROW_REG;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] pick_coord(int unsigned span);
    case ($urandom_range(9))
      0: return $urandom_range(1) ? COORD_MIN : COORD_MAX;
      1, 2: return CoordW'($urandom);
      default: return CoordW'(int'($urandom_range(2 * span)) - int'(span));
    endcase
  endfunction

  task automatic send_word(input logic signed [CoordW-1:0] x, input logic signed [CoordW-1:0] y,
                           input logic last, input bit typed, input score_word_t fixed);
    score_word_t predicted;
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.x_coord <= x;
    in_ch.y_coord <= y;
    in_ch.last_particle <= last;
    do @(posedge clk); while (!in_ch.ready);
    streaming = 1'b1;
    if (absorb_word(x, y, last, predicted)) expected_scores.push_back(typed ? fixed : predicted);
  endtask

  // A word without a score may still be in flight when the queue drains.
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    streaming = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RadW-1:0] val);
    if (streaming) settle();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_INNER: band_inner = val;
      CFG_OUTER: band_outer = val;
      CFG_SIGMA: band_sigma = val;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_scores
    score_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_scores.size() == 0) begin
        errors++;
        $display("%0t: unexpected score word: score %h saturated %b", $time,
                 out_ch.score, out_ch.saturated);
      end else begin
        want = expected_scores.pop_front();
        if (out_ch.score !== want.score) begin
          errors++;
          $display("%0t: score expected %h actual %h", $time, want.score, out_ch.score);
        end
        if (out_ch.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated expected %b actual %b", $time, want.saturated,
                   out_ch.saturated);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("annulus_radial_penalty_sum verification failed");
      $finish;
    end
  end

  initial begin
    stim_row_t    row;
    score_word_t  fixed;
    int           r;
    int           p;
    int           i;
    int unsigned  span;
    logic [RadW-1:0] inner;
    logic [RadW-1:0] outer;
    logic [RadW-1:0] sigma;

    errors = 0;
    cycles = 0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    streaming = 1'b0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.x_coord = '0;
    in_ch.y_coord = '0;
    in_ch.last_particle = 1'b0;
    out_ch.ready = 1'b0;
    band_inner = INNER_RST;
    band_outer = OUTER_RST;
    band_sigma = SIGMA_RST;
    penalty_total = '0;
    total_clipped = 1'b0;

    directed_rows.push_back(word_row(0, 0, 1'b1, 1, 1, '0, 1'b0));
    directed_rows.push_back(word_row(COORD_MIN, COORD_MIN, 1'b0));
    directed_rows.push_back(word_row(COORD_MAX, COORD_MAX, 1'b0));
    directed_rows.push_back(word_row(COORD_MIN, COORD_MAX, 1'b1, 1, 1, '0, 1'b0));
    directed_rows.push_back(word_row(1, -1, 1'b1, 1, 1, '0, 1'b0));
    directed_rows.push_back(reg_row(CFG_SIGMA, 1));
    directed_rows.push_back(reg_row(CFG_INNER, RAD_MAX));
    directed_rows.push_back(word_row(0, 0, 1'b1, 1, 1, 64'h00FF_FFFE_0000_0100, 1'b0));
    directed_rows.push_back(reg_row(CFG_OUTER, 0));
    directed_rows.push_back(word_row(COORD_MAX, COORD_MIN, 1'b0));
    directed_rows.push_back(word_row(12345, -6789, 1'b1));
    directed_rows.push_back(reg_row(CFG_SIGMA, 0));
    directed_rows.push_back(word_row(0, 256, 1'b1));
    directed_rows.push_back(reg_row(CFG_SPARE, 24'h5A5A5A));
    directed_rows.push_back(reg_row(CFG_INNER, 256));
    directed_rows.push_back(reg_row(CFG_OUTER, 512));
    directed_rows.push_back(reg_row(CFG_SIGMA, 384));
    directed_rows.push_back(word_row(128, 0, 1'b0));
    directed_rows.push_back(word_row(384, 0, 1'b0));
    directed_rows.push_back(word_row(768, 1024, 1'b0));
    directed_rows.push_back(word_row(-1024, -768, 1'b1));
    directed_rows.push_back(reg_row(CFG_SIGMA, 1));
    directed_rows.push_back(reg_row(CFG_OUTER, RAD_MAX));
    directed_rows.push_back(reg_row(CFG_INNER, RAD_MAX));
    directed_rows.push_back(word_row(0, 0, 1'b1, OVERFLOW_SET, 1, ACC_SAT, 1'b1));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.kind == ROW_REG) begin
        write_reg(row.idx, row.val);
      end else begin
        fixed.score = row.score;
        fixed.saturated = row.saturated;
        for (r = 0; r < row.reps; r++) begin
          send_word(row.x, row.y, row.last && (r == row.reps - 1), row.typed, fixed);
        end
      end
    end

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 57;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 57;
        end
        default: begin
          src_idle_pct = 6;
          sink_stall_pct = 6;
        end
      endcase
      case (p)
        0: begin
          inner = '0;
          outer = '0;
          sigma = 1;
        end
        1: begin
          inner = RAD_MAX;
          outer = RAD_MAX;
          sigma = RAD_MAX;
        end
        2: begin
          outer = RadW'($urandom_range(1 << 20));
          inner = RadW'($urandom_range(1 << 21, outer));
          sigma = RadW'($urandom_range(1, 4096));
        end
        3: begin
          outer = RadW'($urandom_range(1, 1 << 22));
          inner = RadW'($urandom_range(outer));
          sigma = '0;
        end
        default: begin
          outer = RadW'($urandom_range(1, 1 << 22));
          inner = RadW'($urandom_range(outer));
          sigma = $urandom_range(1) ? RadW'($urandom_range(1, 1024))
                                    : RadW'($urandom_range(1, RAD_MAX));
        end
      endcase
      if (p < 2) span = COORD_MAX;
      else if (p == 2) span = inner + inner / 2 + 16;
      else span = outer + outer / 2 + 16;
      if (span > COORD_MAX) span = COORD_MAX;
      write_reg(CFG_INNER, inner);
      write_reg(CFG_OUTER, outer);
      write_reg(CFG_SIGMA, sigma);
      write_reg(CFG_SPARE, RadW'($urandom));
      for (i = 0; i < WORDS_PER_PHASE; i++) begin
        send_word(pick_coord(span), pick_coord(span),
                  ($urandom_range(7) == 0) || (i == WORDS_PER_PHASE - 1), 1'b0, '0);
      end
    end

    settle();
    if (errors == 0) begin
      $display("annulus_radial_penalty_sum verification clean");
    end else begin
      $display("annulus_radial_penalty_sum verification failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/arps_pkg.sv
rtl/arps_if.sv
rtl/arps_sq.sv
rtl/arps_iter.sv
rtl/annulus_radial_penalty_sum.sv
tb/annulus_radial_penalty_sum_tb.sv
